/* design/polar_phase_frequency_offset_tracker_unit_assert.svh */
// Assertion helpers shared by the tracker RTL.
`ifndef POLAR_PHASE_FREQUENCY_OFFSET_TRACKER_UNIT_ASSERT_SVH
`define POLAR_PHASE_FREQUENCY_OFFSET_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPFOT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPFOT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ppfot_pkg.sv */
package ppfot_pkg;

	localparam int PH_W      = 16;
	localparam int MAG_W     = 16;
	localparam int X_W       = 32;
	localparam int K_W       = 24;
	localparam int DIGIT_W   = 8;
	localparam int NUM_DIGITS = K_W / DIGIT_W;
	localparam int CNT_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int ACC_W     = X_W + DIGIT_W + 2;
	localparam int FRAC_W    = 16;

	// Loop coefficients, 24 fraction bits, rounded to nearest.
	localparam logic [K_W-1:0] K_LEAK  = 24'd16775538;
	localparam logic [K_W-1:0] K_GAIN  = 24'd1678;
	localparam logic [K_W-1:0] K_INTEG = 24'd16777;

	localparam logic signed [X_W-1:0] EST_MAX = 32'sh7fff_ffff;
	localparam logic signed [X_W-1:0] EST_MIN = 32'sh8000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EST,
		ST_FIN1,
		ST_INTEG,
		ST_FIN2,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} mul_ctrl_t;

endpackage

/* design/ppfot_dmul.sv */
// Digit-serial multiply of two signed 32-bit operands by two unsigned 24-bit
// coefficients, summed. One coefficient digit per step, least significant first;
// the partial sum shifts right one digit per step so the adder stays narrow.
// After the last step rnd holds the sum rounded half up at 24 fraction bits.
module ppfot_dmul (
	input  logic                                   clk,
	input  ppfot_pkg::mul_ctrl_t                   ctrl,
	input  logic signed [ppfot_pkg::X_W-1:0]       x1,
	input  logic signed [ppfot_pkg::X_W-1:0]       x2,
	input  logic        [ppfot_pkg::K_W-1:0]       k1,
	input  logic        [ppfot_pkg::K_W-1:0]       k2,
	output logic signed [ppfot_pkg::ACC_W-1:0]     rnd
);

	logic signed [ppfot_pkg::ACC_W-1:0]               acc_q;
	logic        [ppfot_pkg::K_W-1:0]                 lo_q;
	logic        [ppfot_pkg::K_W-1:0]                 k1_q;
	logic        [ppfot_pkg::K_W-1:0]                 k2_q;
	logic signed [ppfot_pkg::X_W+ppfot_pkg::DIGIT_W:0] p1;
	logic signed [ppfot_pkg::X_W+ppfot_pkg::DIGIT_W:0] p2;
	logic signed [ppfot_pkg::ACC_W-1:0]               sum;

	assign p1  = x1 * $signed({1'b0, k1_q[ppfot_pkg::DIGIT_W-1:0]});
	assign p2  = x2 * $signed({1'b0, k2_q[ppfot_pkg::DIGIT_W-1:0]});
	assign sum = acc_q + ppfot_pkg::ACC_W'(p1) + ppfot_pkg::ACC_W'(p2);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			acc_q <= '0;
			lo_q  <= '0;
			k1_q  <= k1;
			k2_q  <= k2;
		end else if (ctrl.step) begin
			acc_q <= sum >>> ppfot_pkg::DIGIT_W;
			lo_q  <= {sum[ppfot_pkg::DIGIT_W-1:0],
				lo_q[ppfot_pkg::K_W-1:ppfot_pkg::DIGIT_W]};
			k1_q  <= k1_q >> ppfot_pkg::DIGIT_W;
			k2_q  <= k2_q >> ppfot_pkg::DIGIT_W;
		end
	end

	// The top bit of the shifted-out fraction is the half-LSB rounding carry.
	assign rnd = acc_q + ppfot_pkg::ACC_W'($signed({1'b0, lo_q[ppfot_pkg::K_W-1]}));

endmodule

/* design/polar_phase_frequency_offset_tracker_unit.sv */
// Phase-domain frequency offset tracker for polar samples. Each input
// transaction carries a magnitude and a 16-bit binary-angle phase; the block
// tracks the sample-to-sample phase step with a leaky estimate, integrates it
// into a correction angle and returns the magnitude unchanged with the phase
// minus that correction. A write on cfg_we loads the frequency estimate
// (Q16.16 angle units per sample). Each item runs two passes of three 8-bit
// digit steps through one shared digit-serial multiply-add unit (two 32x8
// products per step), a finishing state after each pass, a state that moves
// the result into the output register and the idle state in which the next
// transaction is accepted. A new transaction is taken once the previous result
// sits in the output register, so a stalled output holds off input only while
// that register is still full.
`include "polar_phase_frequency_offset_tracker_unit_assert.svh"

module polar_phase_frequency_offset_tracker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] magnitude, [31:16] phase
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] out_magnitude, [31:16] corrected_phase
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata  // init_step
);

	ppfot_pkg::state_t state_q, state_d;
	logic [ppfot_pkg::CNT_W-1:0]             cnt_q;
	logic [ppfot_pkg::PH_W-1:0]              last_phase_q;
	logic signed [ppfot_pkg::X_W-1:0]        est_q;
	logic [ppfot_pkg::X_W-1:0]               corr_q;
	logic [ppfot_pkg::MAG_W-1:0]             mag_q;
	logic [ppfot_pkg::PH_W-1:0]              ph_q;
	logic [ppfot_pkg::PH_W-1:0]              diff_q;
	logic                                    m_tvalid_q;
	logic [31:0]                             m_tdata_q;

	ppfot_pkg::mul_ctrl_t                    mul_ctrl;
	logic signed [ppfot_pkg::X_W-1:0]        mul_x2;
	logic [ppfot_pkg::K_W-1:0]               mul_k1;
	logic [ppfot_pkg::K_W-1:0]               mul_k2;
	logic signed [ppfot_pkg::ACC_W-1:0]      mul_rnd;

	logic                                    s_accept;
	logic                                    cnt_last;
	logic                                    out_load;
	logic                                    est_ovf;
	logic signed [ppfot_pkg::X_W-1:0]        est_sat;
	logic [ppfot_pkg::PH_W-1:0]              corr_int;
	logic [ppfot_pkg::PH_W-1:0]              corrected;

	assign s_tready = (state_q == ppfot_pkg::ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign cnt_last = (cnt_q == ppfot_pkg::CNT_W'(ppfot_pkg::NUM_DIGITS - 1));
	assign out_load = (state_q == ppfot_pkg::ST_DONE) && (!m_tvalid_q || m_tready);

	assign mul_k1 = (state_q == ppfot_pkg::ST_IDLE) ? ppfot_pkg::K_LEAK : ppfot_pkg::K_INTEG;
	assign mul_k2 = (state_q == ppfot_pkg::ST_IDLE) ? ppfot_pkg::K_GAIN : '0;
	// The step term enters as diff * 2^16 so both products share one alignment.
	assign mul_x2 = (state_q == ppfot_pkg::ST_EST) ? $signed({diff_q, 16'h0000}) : '0;

	ppfot_dmul u_dmul (
		.clk  (clk),
		.ctrl (mul_ctrl),
		.x1   (est_q),
		.x2   (mul_x2),
		.k1   (mul_k1),
		.k2   (mul_k2),
		.rnd  (mul_rnd)
	);

	assign est_ovf = !((&mul_rnd[ppfot_pkg::ACC_W-1:ppfot_pkg::X_W-1]) ||
		(~|mul_rnd[ppfot_pkg::ACC_W-1:ppfot_pkg::X_W-1]));
	assign est_sat = est_ovf ? (mul_rnd[ppfot_pkg::ACC_W-1] ? ppfot_pkg::EST_MIN
		: ppfot_pkg::EST_MAX) : mul_rnd[ppfot_pkg::X_W-1:0];

	assign corr_int  = corr_q[ppfot_pkg::X_W-1:ppfot_pkg::FRAC_W] +
		ppfot_pkg::PH_W'(corr_q[ppfot_pkg::FRAC_W-1]);
	assign corrected = ph_q - corr_int;

	always_comb begin
		state_d       = state_q;
		mul_ctrl.load = 1'b0;
		mul_ctrl.step = 1'b0;
		case (state_q)
			ppfot_pkg::ST_IDLE: begin
				if (s_accept) begin
					mul_ctrl.load = 1'b1;
					state_d       = ppfot_pkg::ST_EST;
				end
			end
			ppfot_pkg::ST_EST: begin
				mul_ctrl.step = 1'b1;
				if (cnt_last) begin
					state_d = ppfot_pkg::ST_FIN1;
				end
			end
			ppfot_pkg::ST_FIN1: begin
				mul_ctrl.load = 1'b1;
				state_d       = ppfot_pkg::ST_INTEG;
			end
			ppfot_pkg::ST_INTEG: begin
				mul_ctrl.step = 1'b1;
				if (cnt_last) begin
					state_d = ppfot_pkg::ST_FIN2;
				end
			end
			ppfot_pkg::ST_FIN2: begin
				state_d = ppfot_pkg::ST_DONE;
			end
			ppfot_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = ppfot_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ppfot_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ppfot_pkg::ST_IDLE;
			cnt_q        <= '0;
			last_phase_q <= '0;
			est_q        <= '0;
			corr_q       <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_ctrl.load) begin
				cnt_q <= '0;
			end else if (mul_ctrl.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (s_accept) begin
				last_phase_q <= s_tdata[31:16];
			end
			if (cfg_we) begin
				est_q <= $signed(cfg_wdata);
			end else if (state_q == ppfot_pkg::ST_FIN1) begin
				est_q <= est_sat;
			end
			if (state_q == ppfot_pkg::ST_FIN2) begin
				corr_q <= corr_q + mul_rnd[ppfot_pkg::X_W-1:0];
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			mag_q  <= s_tdata[15:0];
			ph_q   <= s_tdata[31:16];
			diff_q <= s_tdata[31:16] - last_phase_q;
		end
		if (out_load) begin
			m_tdata_q <= {corrected, mag_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`PPFOT_ASSERT_NOW(a_mul_ctrl_excl, clk, arst_n, 1'b1,
		!(mul_ctrl.load && mul_ctrl.step), "multiplier load and step at once")
	`PPFOT_ASSERT_NEXT(a_accept_starts, clk, arst_n, s_accept,
		(state_q == ppfot_pkg::ST_EST) && (cnt_q == '0), "accepted item did not start")
	`PPFOT_ASSERT_NOW(a_fin2_latency, clk, arst_n, state_q == ppfot_pkg::ST_FIN2,
		$past(s_accept, 8), "correction update not eight cycles after accept")
	`PPFOT_ASSERT_NEXT(a_done_holds, clk, arst_n,
		(state_q == ppfot_pkg::ST_DONE) && m_tvalid && !m_tready,
		(state_q == ppfot_pkg::ST_DONE) && m_tvalid, "result lost under stall")

endmodule
